### sv/cdpc_pkg.sv
// Shared widths, register indexes and reset values for the color distance classifier.
// No dependencies; imported by the top level.
package cdpc_pkg;

  localparam int CHAN_W    = 8;   // one color channel
  localparam int SUM_W     = 10;  // r+g+b+1, at most 766
  localparam int THR_W     = 10;  // distance threshold register
  localparam int PROD_W    = 18;  // channel times a color sum
  localparam int ACC_W     = 20;  // sum of three product differences
  localparam int IT_W      = 20;  // pixel sum times target sum
  localparam int ACC255_W  = 28;  // accumulated distance times 255
  localparam int THR_IT_W  = 30;  // threshold times both sums
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    REG_TARGET_RED   = 3'd0,
    REG_TARGET_GREEN = 3'd1,
    REG_TARGET_BLUE  = 3'd2,
    REG_DIST_THRESH  = 3'd3,
    REG_NORM_MODE    = 3'd4
  } reg_idx_t;

  localparam logic [CHAN_W-1:0] TARGET_RED_RST   = 8'd255;
  localparam logic [CHAN_W-1:0] TARGET_GREEN_RST = 8'd0;
  localparam logic [CHAN_W-1:0] TARGET_BLUE_RST  = 8'd0;
  localparam logic [THR_W-1:0]  DIST_THRESH_RST  = 10'd200;
  localparam logic              NORM_MODE_RST    = 1'b1;

endpackage

### sv/color_distance_pixel_classifier_top.sv
// Top level of the color distance pixel classifier: register port, input skid stage
// and a four-stage compare pipeline. Depends on cdpc_pkg.
//
// Usage: one RGB pixel item enters on in_valid/in_stall; one result item (match bit
// and output pixel) leaves on out_valid/out_stall. The output pixel is the target
// color when the pixel matches and black otherwise. The target color, threshold and
// mode live in five APB registers; the user must write them only while the
// pipeline is empty, which the block itself does not enforce. Throughput is one
// item per cycle while the receiver does not stall. The pipeline has three compute
// stages (sums and raw distance, the cross products, the accumulation and threshold
// product) followed by the output register that holds the final compare.
// When the receiver stalls while a result is waiting, the whole pipeline freezes
// in place. An item that arrives in that same cycle is caught in a one-entry skid
// register, so in_stall is a plain flop and never depends combinationally on
// out_stall. The skid entry drains first once the output moves again.
// Reset (synchronous, active high) empties the pipeline and the skid register and
// loads the registers with their reset values: target pure red, threshold 200,
// normalized mode.
module color_distance_pixel_classifier_top
  import cdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Pixel input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] pix_red,
  input  logic [CHAN_W-1:0] pix_green,
  input  logic [CHAN_W-1:0] pix_blue,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic              match
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] target_red, target_green, target_blue;
  logic [THR_W-1:0]  dist_threshold;
  logic              normalize_mode;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // Low address bits are ignored; indexes beyond the last register are dropped.
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_red     <= TARGET_RED_RST;
      target_green   <= TARGET_GREEN_RST;
      target_blue    <= TARGET_BLUE_RST;
      dist_threshold <= DIST_THRESH_RST;
      normalize_mode <= NORM_MODE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_RED:   target_red     <= pwdata[CHAN_W-1:0];
        REG_TARGET_GREEN: target_green   <= pwdata[CHAN_W-1:0];
        REG_TARGET_BLUE:  target_blue    <= pwdata[CHAN_W-1:0];
        REG_DIST_THRESH:  dist_threshold <= pwdata[THR_W-1:0];
        REG_NORM_MODE:    normalize_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_TARGET_RED:   prdata = DATA_W'(target_red);
      REG_TARGET_GREEN: prdata = DATA_W'(target_green);
      REG_TARGET_BLUE:  prdata = DATA_W'(target_blue);
      REG_DIST_THRESH:  prdata = DATA_W'(dist_threshold);
      REG_NORM_MODE:    prdata = DATA_W'(normalize_mode);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance and input skid register
  // ---------------------------------------------------------------------------
  // The whole pipeline moves unless a finished result is held by the receiver.
  logic              adv;
  logic              skid_valid;
  logic [CHAN_W-1:0] skid_red, skid_green, skid_blue;
  logic              src_valid;
  logic [CHAN_W-1:0] src_red, src_green, src_blue;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_valid) begin
      skid_red   <= pix_red;
      skid_green <= pix_green;
      skid_blue  <= pix_blue;
    end
  end

  // The skid entry, when present, goes first; the input is stalled meanwhile.
  assign src_valid = skid_valid || in_valid;
  assign src_red   = skid_valid ? skid_red   : pix_red;
  assign src_green = skid_valid ? skid_green : pix_green;
  assign src_blue  = skid_valid ? skid_blue  : pix_blue;

  function automatic logic [CHAN_W-1:0] diff8(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [PROD_W-1:0] diffp(input logic [PROD_W-1:0] a,
                                              input logic [PROD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 1: color sums and the raw L1 compare
  // ---------------------------------------------------------------------------
  logic              v1;
  logic [CHAN_W-1:0] r1, g1, b1;
  logic [SUM_W-1:0]  isum1, tsum1;
  logic              raw_match1;
  logic [SUM_W-1:0]  raw_dist;

  assign raw_dist = SUM_W'(diff8(src_red, target_red))
                  + SUM_W'(diff8(src_green, target_green))
                  + SUM_W'(diff8(src_blue, target_blue));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1         <= src_red;
      g1         <= src_green;
      b1         <= src_blue;
      isum1      <= SUM_W'(src_red) + SUM_W'(src_green) + SUM_W'(src_blue) + SUM_W'(1);
      tsum1      <= SUM_W'(target_red) + SUM_W'(target_green) + SUM_W'(target_blue)
                  + SUM_W'(1);
      raw_match1 <= raw_dist < dist_threshold;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cross products c*T and t*I, and I*T
  // ---------------------------------------------------------------------------
  logic              v2;
  logic [PROD_W-1:0] cr2, cg2, cb2, tr2, tg2, tb2;
  logic [IT_W-1:0]   it2;
  logic              raw_match2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr2        <= PROD_W'(r1) * PROD_W'(tsum1);
      cg2        <= PROD_W'(g1) * PROD_W'(tsum1);
      cb2        <= PROD_W'(b1) * PROD_W'(tsum1);
      tr2        <= PROD_W'(target_red)   * PROD_W'(isum1);
      tg2        <= PROD_W'(target_green) * PROD_W'(isum1);
      tb2        <= PROD_W'(target_blue)  * PROD_W'(isum1);
      it2        <= IT_W'(isum1) * IT_W'(tsum1);
      raw_match2 <= raw_match1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: accumulated chromaticity distance and threshold*I*T
  // ---------------------------------------------------------------------------
  logic                v3;
  logic [ACC_W-1:0]    acc3;
  logic [THR_IT_W-1:0] thr_it3;
  logic                raw_match3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc3       <= ACC_W'(diffp(cr2, tr2)) + ACC_W'(diffp(cg2, tg2))
                  + ACC_W'(diffp(cb2, tb2));
      thr_it3    <= THR_IT_W'(dist_threshold) * THR_IT_W'(it2);
      raw_match3 <= raw_match2;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: 255*acc < thr*I*T in normalized mode, raw compare otherwise
  // ---------------------------------------------------------------------------
  logic [ACC255_W-1:0] acc255;
  logic                norm_match;
  logic                match_next;

  assign acc255     = (ACC255_W'(acc3) << 8) - ACC255_W'(acc3);
  assign norm_match = THR_IT_W'(acc255) < thr_it3;
  assign match_next = normalize_mode ? norm_match : raw_match3;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      match     <= match_next;
      out_red   <= match_next ? target_red   : '0;
      out_green <= match_next ? target_green : '0;
      out_blue  <= match_next ? target_blue  : '0;
    end
  end

endmodule
